@@ src/line_buffer_sorter_unit_macros.svh @@
// Assertion macros shared by the line buffer sorter checkers.
`ifndef LINE_BUFFER_SORTER_UNIT_MACROS_SVH
`define LINE_BUFFER_SORTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line buffer sorter check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line buffer sorter check failed");

`endif

@@ src/lbs_pkg.sv @@
// Types, sizes and codes shared by the line buffer sorter modules.
`timescale 1ns / 1ps
package lbs_pkg;

  localparam int STORE_BYTES = 4096;
  localparam int LINES_MAX   = 2048;
  localparam int LINE_LIMIT  = 1024;

  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int FILL_W = $clog2(STORE_BYTES + 1);
  localparam int LIDX_W = $clog2(LINES_MAX);
  localparam int LCNT_W = $clog2(LINES_MAX + 1);
  localparam int LEN_W  = $clog2(LINE_LIMIT);

  // Input kinds.
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_EOL   = 2'd1;
  localparam logic [1:0] KIND_EOI   = 2'd2;
  localparam logic [1:0] KIND_FETCH = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_DATA   = 3'd0;
  localparam logic [2:0] ST_EOL    = 3'd1;
  localparam logic [2:0] ST_FIN    = 3'd2;
  localparam logic [2:0] ST_OVF    = 3'd3;
  localparam logic [2:0] ST_SORTED = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_byte;
    logic [11:0] line_count;
  } out_t;

  typedef enum logic [1:0] {
    PH_LOAD,
    PH_OUT,
    PH_DONE,
    PH_ERR
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TERM,
    S_FETCH,
    S_SORT_I,
    S_SORT_KEY,
    S_SORT_J,
    S_SORT_A,
    S_CMP,
    S_SORT_END,
    S_SORT_DONE
  } state_e;

endpackage

@@ src/line_buffer_sorter_unit.sv @@
// Top level of the line buffer sorter: load, sort and read back text lines.
`timescale 1ns / 1ps
// Lines arrive one byte per beat and are packed, zero terminated, into a
// 4096-byte store, with each line's start address kept in a 2048-entry
// table. A character that closes a line at the length limit passes through
// S_TERM, since its byte and the terminator share the byte store's write
// port. A fetch beat reads the registered byte store and emits its result
// from S_FETCH. After an empty line or end of input the start table is
// insertion sorted in place; each comparison reads both lines byte by byte,
// so the number of comparisons can grow with the square of the line count.
// The sort-complete result is emitted from S_SORT_DONE, after S_SORT_END.
// No clearing pass is run after reset.
module line_buffer_sorter_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  lbs_pkg::in_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output lbs_pkg::out_t out_data_o
);

  lbs_pkg::state_e state_q, state_d;
  lbs_pkg::phase_e phase_q, phase_d;

  logic [lbs_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [lbs_pkg::LCNT_W-1:0] lines_q, lines_d;
  logic [lbs_pkg::LEN_W-1:0]  pend_q, pend_d;
  logic [lbs_pkg::ADDR_W-1:0] cursor_q, cursor_d;
  logic [lbs_pkg::LCNT_W-1:0] out_line_q, out_line_d;
  logic [lbs_pkg::ADDR_W-1:0] term_addr_q, term_addr_d;
  logic [lbs_pkg::LCNT_W-1:0] i_q, i_d;
  logic [lbs_pkg::LCNT_W-1:0] j_q, j_d;
  logic [lbs_pkg::ADDR_W-1:0] key_q, key_d;
  logic [lbs_pkg::ADDR_W-1:0] a_q, a_d;
  logic [lbs_pkg::ADDR_W-1:0] ptr_a_q, ptr_a_d;
  logic [lbs_pkg::ADDR_W-1:0] ptr_b_q, ptr_b_d;

  logic          out_valid_q;
  lbs_pkg::out_t out_q;
  logic          emit;
  lbs_pkg::out_t emit_data;

  // Memory ports.
  logic                       bs_we;
  logic [lbs_pkg::ADDR_W-1:0] bs_waddr;
  logic [7:0]                 bs_wdata;
  logic [lbs_pkg::ADDR_W-1:0] bs_raddr_a, bs_raddr_b;
  logic [7:0]                 bs_rdata_a, bs_rdata_b;
  logic                       ls_we;
  logic [lbs_pkg::LIDX_W-1:0] ls_waddr, ls_raddr;
  logic [lbs_pkg::ADDR_W-1:0] ls_wdata, ls_rdata;
  logic [lbs_pkg::ADDR_W-1:0] ls_next;

  // Line closing arithmetic.
  logic                       in_acc;
  logic [lbs_pkg::LEN_W-1:0]  pend_inc, close_len;
  logic [lbs_pkg::FILL_W-1:0] byte_addr, room, need, term_addr;
  logic                       close_ovf;
  logic [lbs_pkg::LCNT_W-1:0] out_line_inc;
  logic signed [7:0]          cmp_x, cmp_y;

  assign in_stall_o = (state_q != lbs_pkg::S_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign pend_inc  = pend_q + lbs_pkg::LEN_W'(1);
  assign close_len = (in_data_i.kind == lbs_pkg::KIND_CHAR) ? pend_inc : pend_q;
  assign byte_addr = fill_q + lbs_pkg::FILL_W'(pend_q);
  assign room      = lbs_pkg::FILL_W'(lbs_pkg::STORE_BYTES) - fill_q;
  assign need      = lbs_pkg::FILL_W'(close_len) + lbs_pkg::FILL_W'(1);
  assign term_addr = fill_q + lbs_pkg::FILL_W'(close_len);
  assign close_ovf = (lines_q >= lbs_pkg::LCNT_W'(lbs_pkg::LINES_MAX)) || (room < need);
  assign out_line_inc = out_line_q + lbs_pkg::LCNT_W'(1);
  assign cmp_x = $signed(bs_rdata_a);
  assign cmp_y = $signed(bs_rdata_b);

  lbs_ram #(
    .WIDTH(8),
    .DEPTH(lbs_pkg::STORE_BYTES)
  ) u_byte_store (
    .clk_i    (clk_i),
    .we_i     (bs_we),
    .waddr_i  (bs_waddr),
    .wdata_i  (bs_wdata),
    .raddr_a_i(bs_raddr_a),
    .rdata_a_o(bs_rdata_a),
    .raddr_b_i(bs_raddr_b),
    .rdata_b_o(bs_rdata_b)
  );

  // Port a serves the sort, port b the next line start during read back.
  lbs_ram #(
    .WIDTH(lbs_pkg::ADDR_W),
    .DEPTH(lbs_pkg::LINES_MAX)
  ) u_line_starts (
    .clk_i    (clk_i),
    .we_i     (ls_we),
    .waddr_i  (ls_waddr),
    .wdata_i  (ls_wdata),
    .raddr_a_i(ls_raddr),
    .rdata_a_o(ls_rdata),
    .raddr_b_i(out_line_inc[lbs_pkg::LIDX_W-1:0]),
    .rdata_b_o(ls_next)
  );

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lbs_pkg::S_IDLE;
      phase_q    <= lbs_pkg::PH_LOAD;
      fill_q     <= '0;
      lines_q    <= '0;
      pend_q     <= '0;
      cursor_q   <= '0;
      out_line_q <= '0;
      i_q        <= '0;
      j_q        <= '0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      fill_q     <= fill_d;
      lines_q    <= lines_d;
      pend_q     <= pend_d;
      cursor_q   <= cursor_d;
      out_line_q <= out_line_d;
      i_q        <= i_d;
      j_q        <= j_d;
    end
  end

  // Sort operands and the terminator address need no reset.
  always_ff @(posedge clk_i) begin
    term_addr_q <= term_addr_d;
    key_q       <= key_d;
    a_q         <= a_d;
    ptr_a_q     <= ptr_a_d;
    ptr_b_q     <= ptr_b_d;
  end

  // Output register; a result is only made while the register is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= emit_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequencer: loading, insertion sort and read back.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    fill_d      = fill_q;
    lines_d     = lines_q;
    pend_d      = pend_q;
    cursor_d    = cursor_q;
    out_line_d  = out_line_q;
    term_addr_d = term_addr_q;
    i_d         = i_q;
    j_d         = j_q;
    key_d       = key_q;
    a_d         = a_q;
    ptr_a_d     = ptr_a_q;
    ptr_b_d     = ptr_b_q;
    emit        = 1'b0;
    emit_data   = '0;
    bs_we       = 1'b0;
    bs_waddr    = term_addr[lbs_pkg::ADDR_W-1:0];
    bs_wdata    = 8'd0;
    bs_raddr_a  = cursor_q;
    bs_raddr_b  = ptr_b_q;
    ls_we       = 1'b0;
    ls_waddr    = lines_q[lbs_pkg::LIDX_W-1:0];
    ls_wdata    = fill_q[lbs_pkg::ADDR_W-1:0];
    ls_raddr    = out_line_inc[lbs_pkg::LIDX_W-1:0];

    unique case (state_q)
      lbs_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (phase_q)
            lbs_pkg::PH_LOAD: begin
              if (in_data_i.kind == lbs_pkg::KIND_CHAR) begin
                if (in_data_i.ch != 8'd0) begin
                  // Store the byte, then close the line at the length limit.
                  if (byte_addr < lbs_pkg::FILL_W'(lbs_pkg::STORE_BYTES)) begin
                    bs_we    = 1'b1;
                    bs_waddr = byte_addr[lbs_pkg::ADDR_W-1:0];
                    bs_wdata = in_data_i.ch;
                  end
                  pend_d = pend_inc;
                  if (pend_inc >= lbs_pkg::LEN_W'(lbs_pkg::LINE_LIMIT - 1)) begin
                    pend_d = '0;
                    if (close_ovf) begin
                      phase_d   = lbs_pkg::PH_ERR;
                      emit      = 1'b1;
                      emit_data.status = lbs_pkg::ST_OVF;
                    end else begin
                      ls_we       = 1'b1;
                      lines_d     = lines_q + lbs_pkg::LCNT_W'(1);
                      fill_d      = fill_q + need;
                      term_addr_d = term_addr[lbs_pkg::ADDR_W-1:0];
                      state_d     = lbs_pkg::S_TERM;
                    end
                  end
                end
              end else if (in_data_i.kind == lbs_pkg::KIND_EOL ||
                           in_data_i.kind == lbs_pkg::KIND_EOI) begin
                if (pend_q != '0) begin
                  pend_d = '0;
                  if (close_ovf) begin
                    phase_d   = lbs_pkg::PH_ERR;
                    emit      = 1'b1;
                    emit_data.status = lbs_pkg::ST_OVF;
                  end else begin
                    bs_we   = 1'b1;
                    ls_we   = 1'b1;
                    lines_d = lines_q + lbs_pkg::LCNT_W'(1);
                    fill_d  = fill_q + need;
                    if (in_data_i.kind == lbs_pkg::KIND_EOI) begin
                      i_d     = lbs_pkg::LCNT_W'(1);
                      state_d = lbs_pkg::S_SORT_I;
                    end
                  end
                end else begin
                  i_d     = lbs_pkg::LCNT_W'(1);
                  state_d = lbs_pkg::S_SORT_I;
                end
              end
            end
            lbs_pkg::PH_OUT: begin
              if (in_data_i.kind == lbs_pkg::KIND_FETCH) begin
                if (out_line_q >= lines_q) begin
                  phase_d   = lbs_pkg::PH_DONE;
                  emit      = 1'b1;
                  emit_data.status = lbs_pkg::ST_FIN;
                end else begin
                  // Byte and next line start are read now, used next cycle.
                  state_d = lbs_pkg::S_FETCH;
                end
              end
            end
            lbs_pkg::PH_DONE: begin
              if (in_data_i.kind == lbs_pkg::KIND_FETCH) begin
                emit      = 1'b1;
                emit_data.status = lbs_pkg::ST_FIN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      lbs_pkg::S_TERM: begin
        bs_we    = 1'b1;
        bs_waddr = term_addr_q;
        state_d  = lbs_pkg::S_IDLE;
      end

      lbs_pkg::S_FETCH: begin
        emit = 1'b1;
        if (bs_rdata_a == 8'd0) begin
          out_line_d = out_line_inc;
          if (out_line_inc < lines_q) begin
            cursor_d = ls_next;
          end
          emit_data.status = lbs_pkg::ST_EOL;
        end else begin
          cursor_d = cursor_q + lbs_pkg::ADDR_W'(1);
          emit_data.status   = lbs_pkg::ST_DATA;
          emit_data.out_byte = bs_rdata_a;
        end
        state_d = lbs_pkg::S_IDLE;
      end

      lbs_pkg::S_SORT_I: begin
        ls_raddr = i_q[lbs_pkg::LIDX_W-1:0];
        state_d  = (i_q >= lines_q) ? lbs_pkg::S_SORT_END : lbs_pkg::S_SORT_KEY;
      end

      lbs_pkg::S_SORT_KEY: begin
        key_d   = ls_rdata;
        j_d     = i_q;
        state_d = lbs_pkg::S_SORT_J;
      end

      lbs_pkg::S_SORT_J: begin
        ls_raddr = lbs_pkg::LIDX_W'(j_q - lbs_pkg::LCNT_W'(1));
        if (j_q == '0) begin
          ls_we    = 1'b1;
          ls_waddr = '0;
          ls_wdata = key_q;
          i_d      = i_q + lbs_pkg::LCNT_W'(1);
          state_d  = lbs_pkg::S_SORT_I;
        end else begin
          state_d = lbs_pkg::S_SORT_A;
        end
      end

      lbs_pkg::S_SORT_A: begin
        // Start the byte-by-byte compare of line j-1 against the key line.
        a_d        = ls_rdata;
        ptr_a_d    = ls_rdata;
        ptr_b_d    = key_q;
        bs_raddr_a = ls_rdata;
        bs_raddr_b = key_q;
        state_d    = lbs_pkg::S_CMP;
      end

      lbs_pkg::S_CMP: begin
        ls_waddr = j_q[lbs_pkg::LIDX_W-1:0];
        if (cmp_x != cmp_y && cmp_x > cmp_y) begin
          // Line j-1 sorts after the key: shift it up one place.
          ls_we    = 1'b1;
          ls_wdata = a_q;
          j_d      = j_q - lbs_pkg::LCNT_W'(1);
          state_d  = lbs_pkg::S_SORT_J;
        end else if (cmp_x != cmp_y || cmp_x == 8'sd0) begin
          ls_we    = 1'b1;
          ls_wdata = key_q;
          i_d      = i_q + lbs_pkg::LCNT_W'(1);
          state_d  = lbs_pkg::S_SORT_I;
        end else begin
          ptr_a_d    = ptr_a_q + lbs_pkg::ADDR_W'(1);
          ptr_b_d    = ptr_b_q + lbs_pkg::ADDR_W'(1);
          bs_raddr_a = ptr_a_q + lbs_pkg::ADDR_W'(1);
          bs_raddr_b = ptr_b_q + lbs_pkg::ADDR_W'(1);
        end
      end

      lbs_pkg::S_SORT_END: begin
        ls_raddr = '0;
        state_d  = lbs_pkg::S_SORT_DONE;
      end

      lbs_pkg::S_SORT_DONE: begin
        cursor_d   = (lines_q != '0) ? ls_rdata : '0;
        out_line_d = '0;
        phase_d    = lbs_pkg::PH_OUT;
        emit       = 1'b1;
        emit_data.status     = lbs_pkg::ST_SORTED;
        emit_data.line_count = 12'(lines_q);
        state_d    = lbs_pkg::S_IDLE;
      end

      default: begin
        state_d = lbs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ src/lbs_ram.sv @@
// Generic synchronous RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
module lbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

@@ src/lbs_checker.sv @@
// Port-level checker for the line buffer sorter and its bind.
`timescale 1ns / 1ps
`include "line_buffer_sorter_unit_macros.svh"
module lbs_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input lbs_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input lbs_pkg::out_t out_data_o
);

  // A stalled result beat holds.
  `LBS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // Status is always one of the defined codes.
  `LBS_ASSERT_NOW(a_status_ok, out_valid_o, out_data_o.status <= lbs_pkg::ST_SORTED)

  // Only data beats carry a byte.
  `LBS_ASSERT_NOW(a_byte_zero, out_valid_o && out_data_o.status != lbs_pkg::ST_DATA, out_data_o.out_byte == 8'd0)

  // Only the sort-complete beat carries a line count.
  `LBS_ASSERT_NOW(a_count_zero, out_valid_o && out_data_o.status != lbs_pkg::ST_SORTED, out_data_o.line_count == 12'd0)

endmodule

bind line_buffer_sorter_unit lbs_checker u_lbs_checker (.*);

@@ tb/sv/tb_line_buffer_sorter_unit.sv @@
// Testbench for the line buffer sorter: random line set, sorted read-back, finished phase.
`timescale 1ns / 1ps
module tb_line_buffer_sorter_unit;
  import lbs_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  line_buffer_sorter_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Shadow state of the sorter.
  logic [7:0]        shadow_store [STORE_BYTES];
  logic [ADDR_W-1:0] shadow_starts [LINES_MAX];
  int unsigned       fill_ptr;
  int unsigned       held_lines;
  int unsigned       pend_len;
  phase_e            cur_phase;
  int unsigned       cursor;
  int unsigned       line_idx;

  in_t  beat_queue [$];
  out_t expected_results [$];
  int   mismatch_count;
  bit   sender_done;
  bit   hold_receiver;
  int   drv_gap;
  int   rx_gap;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int signed_byte(int unsigned addr);
    int v;
    if (addr >= STORE_BYTES) return 0;
    v = shadow_store[addr];
    return (v >= 128) ? v - 256 : v;
  endfunction

  // Positive when the line at a sorts after the line at b.
  function automatic int compare_lines(int unsigned a, int unsigned b);
    int x;
    int y;
    for (int unsigned k = 0; k < STORE_BYTES; k++) begin
      x = signed_byte(a + k);
      y = signed_byte(b + k);
      if (x != y) return x - y;
      if (x == 0) return 0;
    end
    return 0;
  endfunction

  function automatic void sort_starts();
    logic [ADDR_W-1:0] key;
    int unsigned j;
    for (int unsigned i = 1; i < held_lines; i++) begin
      key = shadow_starts[i];
      j = i;
      while (j > 0 && compare_lines(shadow_starts[j-1], key) > 0) begin
        shadow_starts[j] = shadow_starts[j-1];
        j--;
      end
      shadow_starts[j] = key;
    end
  endfunction

  function automatic void push_result(logic [2:0] st, logic [7:0] b, logic [11:0] n);
    out_t r;
    r.status = st;
    r.out_byte = b;
    r.line_count = n;
    expected_results.push_back(r);
  endfunction

  // Returns 0 when the line does not fit.
  function automatic bit close_line();
    int unsigned len;
    len = pend_len;
    pend_len = 0;
    if (held_lines >= LINES_MAX || STORE_BYTES - fill_ptr < len + 1) return 1'b0;
    shadow_store[fill_ptr + len] = 8'd0;
    shadow_starts[held_lines] = fill_ptr[ADDR_W-1:0];
    held_lines++;
    fill_ptr += len + 1;
    return 1'b1;
  endfunction

  function automatic void raise_overflow();
    cur_phase = PH_ERR;
    push_result(ST_OVF, 8'd0, 12'd0);
  endfunction

  function automatic void finish_loading();
    sort_starts();
    cur_phase = PH_OUT;
    line_idx = 0;
    cursor = (held_lines > 0) ? shadow_starts[0] : 0;
    push_result(ST_SORTED, 8'd0, held_lines[11:0]);
  endfunction

  function automatic void predict_beat(in_t b);
    logic [7:0] v;
    if (cur_phase == PH_LOAD) begin
      if (b.kind == KIND_CHAR) begin
        if (b.ch == 8'd0) return;
        if (fill_ptr + pend_len < STORE_BYTES) shadow_store[fill_ptr + pend_len] = b.ch;
        pend_len++;
        if (pend_len >= LINE_LIMIT - 1 && !close_line()) raise_overflow();
      end else if (b.kind == KIND_EOL || b.kind == KIND_EOI) begin
        if (pend_len > 0) begin
          if (!close_line()) begin
            raise_overflow();
            return;
          end
          if (b.kind == KIND_EOL) return;
        end
        finish_loading();
      end
      return;
    end
    if (b.kind != KIND_FETCH) return;
    if (cur_phase == PH_DONE) begin
      push_result(ST_FIN, 8'd0, 12'd0);
      return;
    end
    if (cur_phase != PH_OUT) return;
    if (line_idx >= held_lines) begin
      cur_phase = PH_DONE;
      push_result(ST_FIN, 8'd0, 12'd0);
      return;
    end
    v = (cursor < STORE_BYTES) ? shadow_store[cursor] : 8'd0;
    if (v == 8'd0) begin
      line_idx++;
      if (line_idx < held_lines) cursor = shadow_starts[line_idx];
      push_result(ST_EOL, 8'd0, 12'd0);
    end else begin
      cursor++;
      push_result(ST_DATA, v, 12'd0);
    end
  endfunction

  function automatic void add_beat(logic [1:0] k, logic [7:0] c);
    in_t b;
    b.kind = k;
    b.ch = c;
    beat_queue.push_back(b);
  endfunction

  function automatic logic [7:0] rand_char();
    // Mostly a small alphabet so that lines share prefixes; sometimes any nonzero byte.
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(1, 255));
    return 8'($urandom_range(8'h7e, 8'h82));
  endfunction

  function automatic int stray_count();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // Idle stretch: mostly none, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 30);
    return ($urandom_range(0, 2) == 0) ? 1 : 0;
  endfunction

  // Driver: a beat stays on the bus until accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      drv_gap = 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) predict_beat(in_data_i);
      if (beat_queue.size() > 0 && drv_gap == 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= beat_queue.pop_front();
        drv_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
        if (drv_gap > 0) drv_gap--;
      end
    end
  end

  // Monitor: compare each accepted result beat with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_r;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %p", out_data_o);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data_o !== exp_r) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %p, got %p", exp_r, out_data_o);
          end
        end
      end
      out_stall_i <= hold_receiver || (rx_gap > 0);
      if (rx_gap > 0) rx_gap--;
      else rx_gap = pick_gap();
    end
  end

  // One long hold-off on the result side during read-back while fetches keep coming.
  initial begin
    hold_receiver = 1'b0;
    wait (rst_ni);
    wait (cur_phase == PH_OUT);
    repeat (40) @(posedge clk_i);
    hold_receiver <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_receiver <= 1'b0;
  end

  initial begin
    #200_000_000;
    $display("[line_buffer_sorter_unit] ERROR");
    $finish;
  end

  // Stimulus: one session from reset, a random line set, then a full read-back.
  initial begin
    int n;
    int len;
    int bytes_held;
    int lines_made;
    cur_phase = PH_LOAD;
    fill_ptr = 0;
    held_lines = 0;
    pend_len = 0;
    cursor = 0;
    line_idx = 0;
    mismatch_count = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: fetch while loading, zero byte, extremes, newline byte, shared prefix.
    add_beat(KIND_FETCH, 8'd0);
    add_beat(KIND_CHAR, 8'd0);
    add_beat(KIND_CHAR, 8'hff);
    add_beat(KIND_CHAR, 8'h01);
    add_beat(KIND_EOL, 8'hff);
    add_beat(KIND_CHAR, 8'h7f);
    add_beat(KIND_CHAR, 8'h80);
    add_beat(KIND_EOL, 8'd0);
    add_beat(KIND_CHAR, 8'd10);
    add_beat(KIND_CHAR, 8'h55);
    add_beat(KIND_EOL, 8'd0);
    add_beat(KIND_CHAR, 8'h7f);
    add_beat(KIND_EOL, 8'd0);
    add_beat(KIND_CHAR, 8'h7f);
    add_beat(KIND_CHAR, 8'haa);
    add_beat(KIND_EOL, 8'd0);
    bytes_held = 9;
    lines_made = 5;

    // Random lines, with fetches and zero bytes that loading ignores.
    n = 0;
    while (n < 380) begin
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 15) == 0) begin
          add_beat(KIND_FETCH, 8'($urandom));
          n++;
        end
        if ($urandom_range(0, 15) == 0) begin
          add_beat(KIND_CHAR, 8'd0);
          n++;
        end
        add_beat(KIND_CHAR, rand_char());
        n++;
      end
      add_beat(KIND_EOL, 8'($urandom));
      n++;
      bytes_held += len;
      lines_made++;
    end

    // A last line that end of input closes.
    add_beat(KIND_CHAR, rand_char());
    add_beat(KIND_CHAR, rand_char());
    add_beat(KIND_EOI, 8'd0);
    bytes_held += 2;
    lines_made++;

    // Read-back with stray beats the output phase ignores, then a few finished fetches.
    for (int i = 0; i < bytes_held + lines_made + 4; i++) begin
      if (stray_count() != 0)
        add_beat(($urandom_range(0, 1) == 0) ? KIND_CHAR : KIND_EOL, rand_char());
      add_beat(KIND_FETCH, 8'($urandom));
    end

    wait (beat_queue.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[line_buffer_sorter_unit] OK");
    end else begin
      $display("[line_buffer_sorter_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ line_buffer_sorter_unit.f @@
+incdir+src
src/lbs_pkg.sv
src/lbs_ram.sv
src/line_buffer_sorter_unit.sv
src/lbs_checker.sv
tb/sv/tb_line_buffer_sorter_unit.sv
